@@ rtl/core/mmt_pkg.sv @@
// ----------------------------------------------------------------------------
// mmt_pkg
// types, codes and helpers shared by the transposed int32 matrix multiplier
// ----------------------------------------------------------------------------
package mmt_pkg;

   localparam logic [1:0] CMD_WRITE_A = 2'd0;
   localparam logic [1:0] CMD_WRITE_B = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   localparam logic [1:0] REG_ROWS_M  = 2'd0;
   localparam logic [1:0] REG_COLS_N  = 2'd1;
   localparam logic [1:0] REG_DEPTH_K = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int ROWS_W      = 6;
   localparam int COLS_W      = 6;
   localparam int DEPTH_W     = 7;

   typedef struct packed {
      logic        [1:0]  command;
      logic        [4:0]  row_index;
      logic        [5:0]  col_index;
      logic signed [31:0] value;
   } mmt_req_type;

   typedef struct packed {
      logic        [4:0]  entry_row;
      logic        [5:0]  entry_col;
      logic signed [31:0] dot;
      logic               range_error;
   } mmt_rsp_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } mmt_mac_ctl_type;

   // zero reads as one, anything above the build maximum saturates
   function automatic logic [6:0] clamp_dim(input logic [6:0] v, input int unsigned maxv);
      logic [6:0] r;
      if (v == 7'd0) begin
         r = 7'd1;
      end else if (32'(v) > maxv) begin
         r = 7'(maxv);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/mmt_store.sv @@
// ----------------------------------------------------------------------------
// mmt_store
// single write, single read synchronous element memory, registered read data
// ----------------------------------------------------------------------------
module mmt_store #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [31:0]       wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] ram [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mmt_mac.sv @@
// ----------------------------------------------------------------------------
// mmt_mac
// registered 32x32 multiply followed by a wrapping 32-bit accumulator
// ----------------------------------------------------------------------------
module mmt_mac (
   input  logic                     clock,
   input  logic                     reset,
   input  mmt_pkg::mmt_mac_ctl_type ctl,
   input  logic [31:0]              a_elem,
   input  logic [31:0]              b_elem,
   output logic [31:0]              acc,
   output logic                     pending
);
   import mmt_pkg::*;

   logic [31:0] prod_ff;
   logic [31:0] prod_in;
   logic        prod_vld_ff;
   logic        prod_vld_in;
   logic [31:0] acc_ff;
   logic [31:0] acc_in;

   // low half of the product is the same for signed and unsigned operands
   assign prod_in     = a_elem * b_elem;
   assign prod_vld_in = ctl.valid;

   always_comb begin
      priority if (ctl.clear) begin
         acc_in = 32'd0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc     = acc_ff;
   assign pending = prod_vld_ff;

endmodule

@@ rtl/core/int32_matrix_multiply_transposed.sv @@
// ----------------------------------------------------------------------------
// int32_matrix_multiply_transposed
// C = A * transpose(B) over signed 32-bit words, one output entry per compute
// ----------------------------------------------------------------------------
// writes leave the block idle; the next word may follow at once
// compute: busy from start until rsp_valid rises, walking depth_k in the run state
//   with one multiply-accumulate per cycle from the element memory read port
// out-of-range compute: error word on rsp_valid the cycle after start
// synchronous reset: config returns to 32/32/64, element memories are left as is
// ----------------------------------------------------------------------------
module int32_matrix_multiply_transposed #(
   parameter int MAX_ROWS  = 32,
   parameter int MAX_COLS  = 32,
   parameter int MAX_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mmt_pkg::mmt_req_type                req_word,
   output logic                                rsp_valid,
   output mmt_pkg::mmt_rsp_type                rsp_word,
   input  logic                                csr_we,
   input  logic [mmt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mmt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mmt_pkg::*;

   localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
   localparam int B_DEPTH = MAX_COLS * MAX_DEPTH;
   localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [ROWS_W-1:0]  rows_ff, rows_in;
   logic [COLS_W-1:0]  cols_ff, cols_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [ROWS_W-1:0]  rows_eff;
   logic [COLS_W-1:0]  cols_eff;
   logic [DEPTH_W-1:0] depth_eff;

   logic [1:0]         st_ff, st_in;
   logic [DEPTH_W-1:0] t_ff, t_in;
   logic [4:0]         row_ff, row_in;
   logic [5:0]         col_ff, col_in;
   logic               rdv_ff, rdv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mmt_rsp_type        rsp_ff, rsp_in;

   logic               accept;
   logic               wr_a, wr_b;
   logic               cmp_ok;
   logic [A_AW-1:0]    a_wr_addr, a_rd_addr;
   logic [B_AW-1:0]    b_wr_addr, b_rd_addr;
   logic               rd_en;
   logic [31:0]        a_rd_data, b_rd_data;
   mmt_mac_ctl_type    mac_ctl;
   logic [31:0]        acc;
   logic               mac_pending;

   assign rows_eff  = ROWS_W'(clamp_dim(DEPTH_W'(rows_ff), MAX_ROWS));
   assign cols_eff  = COLS_W'(clamp_dim(DEPTH_W'(cols_ff), MAX_COLS));
   assign depth_eff = clamp_dim(depth_ff, MAX_DEPTH);

   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      depth_in = depth_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ROWS_M:  rows_in  = csr_wdata[ROWS_W-1:0];
            REG_COLS_N:  cols_in  = csr_wdata[COLS_W-1:0];
            REG_DEPTH_K: depth_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept = start && (st_ff == ST_IDLE);
   assign busy   = (st_ff != ST_IDLE);

   // write side, bounds checked against the live config
   assign wr_a = accept && (req_word.command == CMD_WRITE_A)
               && (ROWS_W'(req_word.row_index) < rows_eff)
               && (DEPTH_W'(req_word.col_index) < depth_eff);
   assign wr_b = accept && (req_word.command == CMD_WRITE_B)
               && (COLS_W'(req_word.row_index) < cols_eff)
               && (DEPTH_W'(req_word.col_index) < depth_eff);
   assign a_wr_addr = A_AW'(32'(req_word.row_index) * 32'(MAX_DEPTH)
                     + 32'(req_word.col_index));
   assign b_wr_addr = B_AW'(32'(req_word.row_index) * 32'(MAX_DEPTH)
                     + 32'(req_word.col_index));

   assign cmp_ok = (ROWS_W'(req_word.row_index) < rows_eff)
                 && (COLS_W'(req_word.col_index) < cols_eff);

   // read side walks the inner dimension of A row and B row together
   assign rd_en     = (st_ff == ST_RUN);
   assign a_rd_addr = A_AW'(32'(row_ff) * 32'(MAX_DEPTH) + 32'(t_ff));
   assign b_rd_addr = B_AW'(32'(col_ff) * 32'(MAX_DEPTH) + 32'(t_ff));
   assign rdv_in    = rd_en;

   assign mac_ctl.clear = accept && (req_word.command == CMD_COMPUTE);
   assign mac_ctl.valid = rdv_ff;

   always_comb begin
      st_in        = st_ff;
      t_in         = t_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept && (req_word.command == CMD_COMPUTE)) begin
               row_in = req_word.row_index;
               col_in = req_word.col_index;
               t_in   = '0;
               if (cmp_ok) begin
                  st_in = ST_RUN;
               end else begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.entry_row   = req_word.row_index;
                  rsp_in.entry_col   = req_word.col_index;
                  rsp_in.dot         = '0;
                  rsp_in.range_error = 1'b1;
               end
            end
         end
         ST_RUN: begin
            t_in = t_ff + 1'b1;
            if (t_ff == depth_eff - 1'b1) begin
               st_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rdv_ff && !mac_pending) begin
               st_in              = ST_IDLE;
               rsp_valid_in       = 1'b1;
               rsp_in.entry_row   = row_ff;
               rsp_in.entry_col   = col_ff;
               rsp_in.dot         = acc;
               rsp_in.range_error = 1'b0;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROWS_W'(32);
         cols_ff      <= COLS_W'(32);
         depth_ff     <= DEPTH_W'(64);
         st_ff        <= ST_IDLE;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         depth_ff     <= depth_in;
         st_ff        <= st_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      row_ff <= row_in;
      col_ff <= col_in;
      rsp_ff <= rsp_in;
   end

   mmt_store #(
      .DEPTH (A_DEPTH),
      .AW    (A_AW)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (a_wr_addr),
      .wr_data (req_word.value),
      .rd_en   (rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mmt_store #(
      .DEPTH (B_DEPTH),
      .AW    (B_AW)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (b_wr_addr),
      .wr_data (req_word.value),
      .rd_en   (rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   mmt_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .a_elem  (a_rd_data),
      .b_elem  (b_rd_data),
      .acc     (acc),
      .pending (mac_pending)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
